/* hw/rtl/itp_pkg.sv */
// Shared types, character constants and operator helper functions for the converter.
`timescale 1ns / 1ps

package itp_pkg;

  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_DIG_LO = 8'h30;
  localparam logic [7:0] CHAR_DIG_HI = 8'h39;
  localparam logic [7:0] CHAR_UPP_LO = 8'h41;
  localparam logic [7:0] CHAR_UPP_HI = 8'h5A;
  localparam logic [7:0] CHAR_LOW_LO = 8'h61;
  localparam logic [7:0] CHAR_LOW_HI = 8'h7A;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_PLUS   = 3'd1,
    OP_MINUS  = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4
  } op_code_e;

  typedef enum logic [2:0] {
    KIND_ALNUM,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_OP,
    KIND_OTHER
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RPOP,
    ST_OPOP,
    ST_FLUSH,
    ST_FIN
  } state_e;

  typedef struct packed {
    kind_e      kind;
    op_code_e   op;
    logic [7:0] ch;
    logic       expr_end;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_present;
    logic       run_last;
    logic       expr_done;
    logic       overflow_seen;
  } res_t;

  function automatic logic [7:0] code_char(op_code_e code);
    logic [7:0] c;
    unique case (code)
      OP_LPAREN: c = CHAR_LPAREN;
      OP_PLUS:   c = CHAR_PLUS;
      OP_MINUS:  c = CHAR_MINUS;
      OP_MUL:    c = CHAR_STAR;
      OP_DIV:    c = CHAR_SLASH;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] code_prec(op_code_e code);
    logic [1:0] p;
    unique case (code)
      OP_PLUS, OP_MINUS: p = 2'd1;
      OP_MUL, OP_DIV:    p = 2'd2;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/itp_front.sv */
// Input side: accepts characters and classifies them into commands for the queue.
`timescale 1ns / 1ps

module itp_front import itp_pkg::*; (
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_char
  input  logic       s_axis_tlast,  // expr_end
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output cmd_t       q_cmd_o
);

  logic [7:0] ch;
  logic       is_alnum;

  assign ch = s_axis_tdata;
  assign is_alnum = (ch >= CHAR_DIG_LO && ch <= CHAR_DIG_HI) ||
                    (ch >= CHAR_UPP_LO && ch <= CHAR_UPP_HI) ||
                    (ch >= CHAR_LOW_LO && ch <= CHAR_LOW_HI);

  always_comb begin
    q_cmd_o.ch       = ch;
    q_cmd_o.expr_end = s_axis_tlast;
    q_cmd_o.op       = OP_LPAREN;
    q_cmd_o.kind     = KIND_OTHER;
    priority if (is_alnum) begin
      q_cmd_o.kind = KIND_ALNUM;
    end else if (ch == CHAR_LPAREN) begin
      q_cmd_o.kind = KIND_LPAREN;
    end else if (ch == CHAR_RPAREN) begin
      q_cmd_o.kind = KIND_RPAREN;
    end else if (ch == CHAR_PLUS) begin
      q_cmd_o.kind = KIND_OP;
      q_cmd_o.op   = OP_PLUS;
    end else if (ch == CHAR_MINUS) begin
      q_cmd_o.kind = KIND_OP;
      q_cmd_o.op   = OP_MINUS;
    end else if (ch == CHAR_STAR) begin
      q_cmd_o.kind = KIND_OP;
      q_cmd_o.op   = OP_MUL;
    end else if (ch == CHAR_SLASH) begin
      q_cmd_o.kind = KIND_OP;
      q_cmd_o.op   = OP_DIV;
    end else begin
      q_cmd_o.kind = KIND_OTHER;
    end
  end

  assign q_valid_o     = s_axis_tvalid;
  assign s_axis_tready = q_ready_i;

endmodule

/* hw/rtl/itp_fifo.sv */
// Short command queue between the classifier and the stack engine.
`timescale 1ns / 1ps

module itp_fifo import itp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

/* hw/rtl/itp_exec.sv */
// Stack engine: one operator stack push or pop per cycle unless stalled; drives result register.
`timescale 1ns / 1ps

module itp_exec import itp_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  cmd_t q_cmd_i,
  output logic m_valid_o,
  input  logic m_ready_i,
  output res_t m_res_o
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int IdxW = $clog2(STACK_DEPTH);

  state_e          state_q, state_d;
  cmd_t            cur_q;
  op_code_e        stk_q [STACK_DEPTH];
  logic [CntW-1:0] count_q, count_d;
  logic            flag_q, flag_d;
  logic            hold_valid_q, hold_valid_d;
  logic [7:0]      hold_char_q;
  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;

  logic            stk_empty;
  logic            stk_full;
  logic [IdxW-1:0] top_idx;
  op_code_e        top_op;
  logic            top_is_lp;
  logic            out_free;
  logic            can_prod;
  logic            op_pops;
  state_e          after_cur;
  state_e          after_new;

  logic            load_cur;
  logic            produce;
  logic [7:0]      prod_char;
  logic            pop;
  logic            push;
  op_code_e        push_code;
  logic            fin_load;
  logic            fin_bare;
  logic            out_load;

  assign stk_empty = (count_q == '0);
  assign stk_full  = (count_q == CntW'(STACK_DEPTH));
  assign top_idx   = stk_empty ? '0 : IdxW'(count_q - 1'b1);
  assign top_op    = stk_q[top_idx];
  assign top_is_lp = (top_op == OP_LPAREN);
  assign out_free  = !out_valid_q || m_ready_i;
  assign can_prod  = !hold_valid_q || out_free;
  assign op_pops   = !stk_empty && (code_prec(top_op) >= code_prec(cur_q.op));
  assign after_cur = cur_q.expr_end ? ST_FLUSH : ST_FIN;
  assign after_new = q_cmd_i.expr_end ? ST_FLUSH : ST_FIN;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.kind)
            KIND_RPAREN: state_d = ST_RPOP;
            KIND_OP:     state_d = ST_OPOP;
            default:     state_d = after_new;
          endcase
        end
      end
      ST_RPOP: begin
        if (stk_empty || top_is_lp) begin
          state_d = after_cur;
        end
      end
      ST_OPOP: begin
        if (!op_pops) begin
          state_d = after_cur;
        end
      end
      ST_FLUSH: begin
        if (stk_empty) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (hold_valid_q || cur_q.expr_end) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = 1'b0;
    load_cur  = 1'b0;
    produce   = 1'b0;
    prod_char = code_char(top_op);
    pop       = 1'b0;
    push      = 1'b0;
    push_code = cur_q.op;
    fin_load  = 1'b0;
    fin_bare  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          load_cur = 1'b1;
          if (q_cmd_i.kind == KIND_ALNUM) begin
            produce   = 1'b1;
            prod_char = q_cmd_i.ch;
          end
          if (q_cmd_i.kind == KIND_LPAREN) begin
            push      = 1'b1;
            push_code = OP_LPAREN;
          end
        end
      end
      ST_RPOP, ST_FLUSH: begin
        if (!stk_empty) begin
          if (top_is_lp) begin
            pop = 1'b1;
          end else if (can_prod) begin
            produce = 1'b1;
            pop     = 1'b1;
          end
        end
      end
      ST_OPOP: begin
        if (op_pops) begin
          if (can_prod) begin
            produce = 1'b1;
            pop     = 1'b1;
          end
        end else begin
          push = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          if (hold_valid_q) begin
            fin_load = 1'b1;
          end else if (cur_q.expr_end) begin
            fin_load = 1'b1;
            fin_bare = 1'b1;
          end
        end
      end
      default: begin
        q_ready_o = 1'b0;
      end
    endcase
  end

  assign out_load = (produce && hold_valid_q) || fin_load;

  always_comb begin
    count_d = count_q;
    if (pop) begin
      count_d = count_q - 1'b1;
    end else if (push && !stk_full) begin
      count_d = count_q + 1'b1;
    end
    flag_d = flag_q || (push && stk_full);

    hold_valid_d = hold_valid_q;
    if (produce) begin
      hold_valid_d = 1'b1;
    end else if (fin_load) begin
      hold_valid_d = 1'b0;
    end

    out_d.out_char      = fin_bare ? 8'h00 : hold_char_q;
    out_d.char_present  = !fin_bare;
    out_d.run_last      = fin_load;
    out_d.expr_done     = fin_load && cur_q.expr_end;
    out_d.overflow_seen = flag_q;

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      flag_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      flag_q       <= flag_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cur) begin
      cur_q <= q_cmd_i;
    end
    if (produce) begin
      hold_char_q <= prod_char;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    if (push && !stk_full) begin
      stk_q[IdxW'(count_q)] <= push_code;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

endmodule

/* hw/rtl/infix_to_postfix_converter_unit.sv */
// Top level of the infix to postfix converter.
//
// The slave stream takes one infix character per transaction in tdata, with tlast marking
// the final character of an expression. The master stream gives the postfix characters:
// tdata carries the character, tlast marks the last result of one input transaction, and
// tuser carries the presence flag, the end-of-expression flag and the sticky overflow flag.
// An end-of-expression transaction always yields a result with the end flag set, carrying
// no character when the expression produced nothing more.
// Accepted characters are classified and placed in a two-entry queue; the stack engine then
// handles one stack push or pop per cycle unless stalled by the output. A letter, digit, open
// paren or ignored character passes through the idle and finish states. An operator pops every
// stacked operator of equal or higher precedence, pushes itself and then finishes; a close
// paren pops operators down to its open paren and pops that too. An end transaction then
// flushes every stack entry before finishing. The engine takes the next command from the queue
// only when back in its idle state. Results wait in hold and output registers while the
// classifier keeps filling the queue; when the receiver holds tready low the engine stalls once
// both are full. Reset clears the stack, the queue, the overflow flag and the output register.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit import itp_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_char
  input  logic       s_axis_tlast,  // expr_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_char
  output logic       m_axis_tlast,  // run_last
  output logic [2:0] m_axis_tuser   // [0] char_present, [1] expr_done, [2] overflow_seen
);

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qe_valid;
  logic qe_ready;
  cmd_t qe_cmd;
  res_t res;

  itp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_valid_o     (fq_valid),
    .q_ready_i     (fq_ready),
    .q_cmd_o       (fq_cmd)
  );

  itp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_cmd_i   (fq_cmd),
    .rd_valid_o (qe_valid),
    .rd_ready_i (qe_ready),
    .rd_cmd_o   (qe_cmd)
  );

  itp_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qe_valid),
    .q_ready_o (qe_ready),
    .q_cmd_i   (qe_cmd),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  assign m_axis_tdata = res.out_char;
  assign m_axis_tlast = res.run_last;
  assign m_axis_tuser = {res.overflow_seen, res.expr_done, res.char_present};

endmodule
